FILE: src/doe_pkg.sv
// Shared types and constants for the degeneracy ordering engine.
package doe_pkg;

  localparam int OPCODE_W   = 1;
  localparam int NODE_W     = 7;
  localparam int ID_W       = 6;
  localparam int ORDER_W    = 7;
  localparam int DEG_W      = 6;
  localparam int COUNT_W    = 7;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [OPCODE_W-1:0] OP_ADD_EDGE = 1'b0;
  localparam logic [OPCODE_W-1:0] OP_RUN      = 1'b1;

  localparam logic [COUNT_W-1:0] NODE_COUNT_RESET = 7'd64;

  // register index, taken from paddr[2]
  localparam logic REG_NODE_COUNT = 1'b0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EDGE_RD_A,
    ST_EDGE_WR_A,
    ST_EDGE_WR_B,
    ST_SCAN,
    ST_FLUSH,
    ST_EMIT,
    ST_CLEAR
  } state_t;

  typedef struct packed {
    logic in_ready;
    logic load;
    logic edge_rd_a;
    logic edge_wr_a;
    logic edge_wr_b;
    logic scan_issue;
    logic emit;
    logic clear;
  } ctrl_cmd_t;

  typedef struct packed {
    logic in_valid;
    logic in_run;
    logic edge_ok;
    logic scan_last;
    logic pipe_busy;
    logic out_free;
    logic last_step;
  } ctrl_status_t;

endpackage

FILE: src/doe_if.sv
// Input and result channel interfaces.
interface doe_in_if import doe_pkg::*; ;
  logic                valid;
  logic                ready;
  logic [OPCODE_W-1:0] opcode;
  logic [NODE_W-1:0]   node_a;
  logic [NODE_W-1:0]   node_b;

  modport source (output valid, opcode, node_a, node_b, input ready);
  modport sink   (input valid, opcode, node_a, node_b, output ready);
endinterface

interface doe_out_if import doe_pkg::*; ;
  logic               valid;
  logic               ready;
  logic [ID_W-1:0]    node_id;
  logic [ORDER_W-1:0] removal_order;
  logic [DEG_W-1:0]   degree_at_removal;
  logic [DEG_W-1:0]   degeneracy_so_far;
  logic               last;

  modport source (output valid, node_id, removal_order, degree_at_removal,
                  degeneracy_so_far, last, input ready);
  modport sink   (input valid, node_id, removal_order, degree_at_removal,
                  degeneracy_so_far, last, output ready);
endinterface

FILE: src/degeneracy_ordering_engine.sv
// Edge add: accept, then read-modify-write of both rows.
// Run: for n nodes, each removal scans all n adjacency rows through the single
// read port, then drains a 3-stage degree pipeline.
// Results leave through an output register; one word per removal.
// Reset (rst, synchronous): row valid bits cleared so the matrix reads empty,
// node_count set to 64, controller idle.
module degeneracy_ordering_engine import doe_pkg::*; #(
  parameter int MAX_NODES = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  doe_in_if.sink                item,
  doe_out_if.source             result
);

  logic [COUNT_W-1:0] node_count;
  ctrl_cmd_t          cmd;
  ctrl_status_t       st;
  logic               reg_sel;

  assign reg_sel = paddr[CFG_ADDR_W-1] == REG_NODE_COUNT;
  assign pready  = 1'b1;
  assign prdata  = reg_sel ? CFG_DATA_W'(node_count) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= NODE_COUNT_RESET;
    end else if (psel && penable && pwrite && reg_sel) begin
      node_count <= pwdata[COUNT_W-1:0];
    end
  end

  doe_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .st  (st),
    .cmd (cmd)
  );

  doe_datapath #(.MAX_NODES(MAX_NODES)) u_dp (
    .clk        (clk),
    .rst        (rst),
    .node_count (node_count),
    .cmd        (cmd),
    .st         (st),
    .item       (item),
    .result     (result)
  );

endmodule

FILE: src/doe_adj_mem.sv
// Adjacency row memory with per-row valid bits; invalid rows read with rvalid low.
module doe_adj_mem #(
  parameter int MAX_NODES = 64,
  parameter int IW = $clog2(MAX_NODES)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 clear,
  input  logic                 we,
  input  logic [IW-1:0]        waddr,
  input  logic [MAX_NODES-1:0] wdata,
  input  logic [IW-1:0]        raddr,
  output logic [MAX_NODES-1:0] rdata,
  output logic                 rvalid
);

  logic [MAX_NODES-1:0] mem [MAX_NODES];
  logic [MAX_NODES-1:0] row_valid;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
      rvalid    <= 1'b0;
    end else begin
      rvalid <= row_valid[raddr];
      if (clear) begin
        row_valid <= '0;
      end else if (we) begin
        row_valid[waddr] <= 1'b1;
      end
    end
  end

endmodule

FILE: src/doe_datapath.sv
// Datapath: operand latch, degree scan pipeline, min tracker, result register.
module doe_datapath import doe_pkg::*; #(
  parameter int MAX_NODES = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [COUNT_W-1:0] node_count,
  input  ctrl_cmd_t          cmd,
  output ctrl_status_t       st,
  doe_in_if.sink             item,
  doe_out_if.source          result
);

  localparam int IW    = $clog2(MAX_NODES);
  localparam int CW    = $clog2(MAX_NODES + 1);
  localparam int NL    = (MAX_NODES + 7) / 8;
  localparam int PAD_W = NL * 8;

  logic [IW-1:0]        a_idx, b_idx;
  logic                 edge_ok;
  logic [CW-1:0]        n_eff;
  logic [MAX_NODES-1:0] live;
  logic [IW-1:0]        step;
  logic [CW-1:0]        max_deg;
  logic [IW-1:0]        scan_idx;
  logic [CW-1:0]        best_deg;
  logic [IW-1:0]        best_idx;

  logic                 p1_vld, p2_vld, p3_vld;
  logic [IW-1:0]        p1_idx, p2_idx, p3_idx;
  logic [3:0]           p2_cnt [NL];
  logic [CW-1:0]        p3_deg;

  logic                 mem_we;
  logic [IW-1:0]        mem_waddr, mem_raddr;
  logic [MAX_NODES-1:0] mem_wdata, mem_rdata, row_cur, bit_sel;
  logic                 mem_rvalid;

  logic [CW-1:0]        n_load;
  logic [MAX_NODES-1:0] in_use;
  logic                 ok_load;
  logic [PAD_W-1:0]     masked;
  logic [3:0]           lane_cnt [NL];
  logic [CW-1:0]        deg_sum;
  logic [CW-1:0]        max_next;
  logic                 out_valid;
  logic [ID_W-1:0]      o_id;
  logic [ORDER_W-1:0]   o_order;
  logic [DEG_W-1:0]     o_deg, o_max;
  logic                 o_last;

  // operand decode at accept
  always_comb begin
    if (node_count == '0) begin
      n_load = CW'(1);
    end else if (node_count > COUNT_W'(MAX_NODES)) begin
      n_load = CW'(MAX_NODES);
    end else begin
      n_load = CW'(node_count);
    end
    for (int i = 0; i < MAX_NODES; i++) begin
      in_use[i] = CW'(i) < n_load;
    end
    ok_load = (item.node_a != '0) && (item.node_a <= NODE_W'(MAX_NODES)) &&
              (item.node_b != '0) && (item.node_b <= NODE_W'(MAX_NODES)) &&
              (item.node_a != item.node_b);
  end

  // memory port selection
  always_comb begin
    row_cur   = mem_rvalid ? mem_rdata : '0;
    bit_sel   = {{(MAX_NODES-1){1'b0}}, 1'b1} << (cmd.edge_wr_a ? b_idx : a_idx);
    mem_we    = cmd.edge_wr_a | cmd.edge_wr_b;
    mem_waddr = cmd.edge_wr_a ? a_idx : b_idx;
    mem_wdata = row_cur | bit_sel;
    if (cmd.scan_issue) begin
      mem_raddr = scan_idx;
    end else if (cmd.edge_rd_a) begin
      mem_raddr = a_idx;
    end else begin
      mem_raddr = b_idx;
    end
  end

  doe_adj_mem #(.MAX_NODES(MAX_NODES), .IW(IW)) u_mem (
    .clk    (clk),
    .rst    (rst),
    .clear  (cmd.clear),
    .we     (mem_we),
    .waddr  (mem_waddr),
    .wdata  (mem_wdata),
    .raddr  (mem_raddr),
    .rdata  (mem_rdata),
    .rvalid (mem_rvalid)
  );

  // popcount split into byte lanes, then a lane sum
  always_comb begin
    masked = '0;
    masked[MAX_NODES-1:0] = row_cur & live;
    for (int l = 0; l < NL; l++) begin
      lane_cnt[l] = '0;
      for (int k = 0; k < 8; k++) begin
        lane_cnt[l] = lane_cnt[l] + 4'(masked[l*8+k]);
      end
    end
    deg_sum = '0;
    for (int l = 0; l < NL; l++) begin
      deg_sum = deg_sum + CW'(p2_cnt[l]);
    end
    max_next = (best_deg > max_deg) ? best_deg : max_deg;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_vld    <= 1'b0;
      p2_vld    <= 1'b0;
      p3_vld    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      p1_vld <= cmd.scan_issue & live[scan_idx];
      p2_vld <= p1_vld;
      p3_vld <= p2_vld;
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    p1_idx <= scan_idx;
    p2_idx <= p1_idx;
    p2_cnt <= lane_cnt;
    p3_idx <= p2_idx;
    p3_deg <= deg_sum;

    if (cmd.load) begin
      a_idx   <= IW'(item.node_a - NODE_W'(1));
      b_idx   <= IW'(item.node_b - NODE_W'(1));
      edge_ok <= ok_load;
      n_eff   <= n_load;
      live    <= in_use;
      step    <= '0;
      max_deg <= '0;
    end

    if (cmd.load || cmd.emit) begin
      scan_idx <= '0;
      best_deg <= '1;
    end else begin
      if (cmd.scan_issue) begin
        scan_idx <= scan_idx + IW'(1);
      end
      if (p3_vld && (p3_deg < best_deg)) begin
        best_deg <= p3_deg;
        best_idx <= p3_idx;
      end
    end

    if (cmd.emit) begin
      live[best_idx] <= 1'b0;
      step           <= step + IW'(1);
      max_deg        <= max_next;
      o_id           <= ID_W'(best_idx);
      o_order        <= ORDER_W'(CW'(step) + CW'(1));
      o_deg          <= DEG_W'(best_deg);
      o_max          <= DEG_W'(max_next);
      o_last         <= st.last_step;
    end
  end

  always_comb begin
    st.in_valid  = item.valid;
    st.in_run    = item.opcode == OP_RUN;
    st.edge_ok   = edge_ok;
    st.scan_last = CW'(scan_idx) == (n_eff - CW'(1));
    st.pipe_busy = p1_vld | p2_vld | p3_vld;
    st.out_free  = ~out_valid | result.ready;
    st.last_step = (CW'(step) + CW'(1)) == n_eff;
  end

  assign item.ready               = cmd.in_ready;
  assign result.valid             = out_valid;
  assign result.node_id           = o_id;
  assign result.removal_order     = o_order;
  assign result.degree_at_removal = o_deg;
  assign result.degeneracy_so_far = o_max;
  assign result.last              = o_last;

endmodule

FILE: src/doe_ctrl.sv
// Controller state machine for edge loads and peeling runs.
module doe_ctrl import doe_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  ctrl_status_t st,
  output ctrl_cmd_t    cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      ST_IDLE: begin
        cmd.in_ready = 1'b1;
        if (st.in_valid) begin
          cmd.load   = 1'b1;
          state_next = st.in_run ? ST_SCAN : ST_EDGE_RD_A;
        end
      end
      ST_EDGE_RD_A: begin
        if (st.edge_ok) begin
          cmd.edge_rd_a = 1'b1;
          state_next    = ST_EDGE_WR_A;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_EDGE_WR_A: begin
        cmd.edge_wr_a = 1'b1;
        state_next    = ST_EDGE_WR_B;
      end
      ST_EDGE_WR_B: begin
        cmd.edge_wr_b = 1'b1;
        state_next    = ST_IDLE;
      end
      ST_SCAN: begin
        cmd.scan_issue = 1'b1;
        if (st.scan_last) begin
          state_next = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (!st.pipe_busy) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (st.out_free) begin
          cmd.emit   = 1'b1;
          state_next = st.last_step ? ST_CLEAR : ST_SCAN;
        end
      end
      ST_CLEAR: begin
        cmd.clear  = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule
